/* sv/msgpe_pkg.sv */
// Package for the MessagePack header encoder: mode codes, marker bytes,
// the job descriptor passed from the front end to the serialiser.
// No dependencies.
`timescale 1ns / 1ps

package msgpe_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [2:0] {
		MODE_UINT  = 3'd0,
		MODE_BOOL  = 3'd1,
		MODE_STR   = 3'd2,
		MODE_ARRAY = 3'd3,
		MODE_MAP   = 3'd4,
		MODE_RAW   = 3'd5
	} mode_t;

	// MessagePack marker bytes
	localparam logic [7:0] MK_FIXSTR = 8'ha0;
	localparam logic [7:0] MK_STR8   = 8'hd9;
	localparam logic [7:0] MK_UINT8  = 8'hcc;
	localparam logic [7:0] MK_UINT16 = 8'hcd;
	localparam logic [7:0] MK_UINT32 = 8'hce;
	localparam logic [7:0] MK_UINT64 = 8'hcf;
	localparam logic [7:0] MK_FIXARR = 8'h90;
	localparam logic [7:0] MK_ARR16  = 8'hdc;
	localparam logic [7:0] MK_FIXMAP = 8'h80;
	localparam logic [7:0] MK_MAP16  = 8'hde;
	localparam logic [7:0] MK_TRUE   = 8'hc3;
	localparam logic [7:0] MK_FALSE  = 8'hc2;

	// Descriptor queue depth and derived widths
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One encoded item: head byte, then nbytes taken from the top of payload
	typedef struct packed {
		logic [7:0]  head;
		logic [3:0]  nbytes;
		logic [63:0] payload;
	} desc_t;

endpackage

/* sv/msgpe_front.sv */
// Front end: classifies one input item into a descriptor (marker byte plus
// left-aligned big-endian payload and its byte count). Uses msgpe_pkg.
`timescale 1ns / 1ps

module msgpe_front (
	input  logic [2:0]          mode,
	input  logic [63:0]         value,
	input  logic [15:0]         length,
	input  logic [7:0]          data_byte,
	output msgpe_pkg::desc_t    desc
);
	import msgpe_pkg::*;

	// Pick the shortest form and align its payload to the top byte
	always_comb begin
		desc = '0;
		unique case (mode)
			MODE_UINT: begin
				if (value <= 64'h7f) begin
					desc.head = value[7:0];
				end else if (value <= 64'hff) begin
					desc.head    = MK_UINT8;
					desc.nbytes  = 4'd1;
					desc.payload = {value[7:0], 56'd0};
				end else if (value <= 64'hffff) begin
					desc.head    = MK_UINT16;
					desc.nbytes  = 4'd2;
					desc.payload = {value[15:0], 48'd0};
				end else if (value <= 64'hffff_ffff) begin
					desc.head    = MK_UINT32;
					desc.nbytes  = 4'd4;
					desc.payload = {value[31:0], 32'd0};
				end else begin
					desc.head    = MK_UINT64;
					desc.nbytes  = 4'd8;
					desc.payload = value;
				end
			end
			MODE_BOOL: begin
				desc.head = (value != 64'd0) ? MK_TRUE : MK_FALSE;
			end
			MODE_STR: begin
				// long strings use str8 with the low length byte only
				if (length <= 16'd31) begin
					desc.head = MK_FIXSTR | {3'd0, length[4:0]};
				end else begin
					desc.head    = MK_STR8;
					desc.nbytes  = 4'd1;
					desc.payload = {length[7:0], 56'd0};
				end
			end
			MODE_ARRAY, MODE_MAP: begin
				if (length <= 16'd15) begin
					desc.head = ((mode == MODE_ARRAY) ? MK_FIXARR : MK_FIXMAP)
						| {4'd0, length[3:0]};
				end else begin
					desc.head    = (mode == MODE_ARRAY) ? MK_ARR16 : MK_MAP16;
					desc.nbytes  = 4'd2;
					desc.payload = {length, 48'd0};
				end
			end
			default: begin
				// raw byte, and the unused codes behave the same
				desc.head = data_byte;
			end
		endcase
	end

endmodule

/* sv/msgpe_fifo.sv */
// Short descriptor queue between front end and serialiser.
// Uses msgpe_pkg for the descriptor type and depth.
`timescale 1ns / 1ps

module msgpe_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  msgpe_pkg::desc_t    wdata,
	input  logic                pop,
	output msgpe_pkg::desc_t    rdata,
	output logic                full,
	output logic                empty
);
	import msgpe_pkg::*;

	desc_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/msgpe_back.sv */
// Serialiser: takes descriptors from the queue and emits one byte per cycle
// unless m_tready stalls it, via a registered stream output. Uses msgpe_pkg.
`timescale 1ns / 1ps

module msgpe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  msgpe_pkg::desc_t    desc,
	input  logic                empty,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // [7:0] out_byte
	output logic                m_tlast
);
	import msgpe_pkg::*;

	logic [3:0]  rem_q;     // payload bytes still to send for current item
	logic [63:0] sh_q;      // remaining payload, next byte on top
	logic        tvalid_q;
	logic [7:0]  tdata_q;
	logic        tlast_q;
	logic        out_free;

	assign out_free = !tvalid_q || m_tready;
	assign pop      = out_free && (rem_q == 4'd0) && !empty;
	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

	// Control: payload countdown and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			tvalid_q <= 1'b0;
		end else if (out_free) begin
			if (rem_q != 4'd0) begin
				rem_q    <= rem_q - 4'd1;
				tvalid_q <= 1'b1;
			end else if (!empty) begin
				rem_q    <= desc.nbytes;
				tvalid_q <= 1'b1;
			end else begin
				tvalid_q <= 1'b0;
			end
		end
	end

	// Data path: head byte first, then payload bytes from the top
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (rem_q != 4'd0) begin
				tdata_q <= sh_q[63:56];
				tlast_q <= (rem_q == 4'd1);
				sh_q    <= {sh_q[55:0], 8'd0};
			end else if (!empty) begin
				tdata_q <= desc.head;
				tlast_q <= (desc.nbytes == 4'd0);
				sh_q    <= desc.payload;
			end
		end
	end

endmodule

/* sv/msgpack_header_encoder_core.sv */
// MessagePack header encoder: each accepted transaction becomes 1 to 9 output
// bytes (marker byte, then big-endian payload), one byte per cycle unless
// m_tready stalls the output, with tlast on the final byte. An item has one
// output byte for fixint, bool, fix headers and raw bytes, up to 9 for a
// uint64. The front end accepts a new transaction every cycle while its
// two-entry descriptor queue has room, so classification overlaps
// serialisation of earlier items. No state is kept between items. Depends on
// msgpe_pkg, msgpe_front, msgpe_fifo, msgpe_back.
`timescale 1ns / 1ps

module msgpack_header_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // [63:0] value, [79:64] length, [87:80] data_byte
	input  logic [2:0]  s_tuser,   // [2:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast
);
	import msgpe_pkg::*;

	desc_t cls_desc;
	desc_t q_desc;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	logic  q_push;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Classify incoming item
	msgpe_front u_front (
		.mode      (s_tuser),
		.value     (s_tdata[63:0]),
		.length    (s_tdata[79:64]),
		.data_byte (s_tdata[87:80]),
		.desc      (cls_desc)
	);

	// Decouple front end from serialiser
	msgpe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (cls_desc),
		.pop    (q_pop),
		.rdata  (q_desc),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Emit bytes
	msgpe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.desc     (q_desc),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
